[sv/iqa_pkg.sv]
package iqa_pkg;

    localparam int VAL_W     = 8;   // int8 operands, zero points and result
    localparam int MULT_W    = 31;  // Q31 multiplier, unsigned
    localparam int SHIFT_W   = 6;
    localparam int DIFF_W    = VAL_W + 1;         // operand minus zero point
    localparam int PROD_W    = DIFF_W + MULT_W;   // signed product
    localparam int TERM_W    = PROD_W + 1;        // rounded term, incl. headroom
    localparam int ACC_W     = PROD_W + 2;        // rounding adder and final sum
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = MULT_W;

    // beyond this shift the rounded term of any product is zero
    localparam logic [SHIFT_W-1:0] SHIFT_ZERO_ABOVE = SHIFT_W'(PROD_W);

    localparam logic signed [ACC_W-1:0] SUM_MIN = -128;
    localparam logic signed [ACC_W-1:0] SUM_MAX = 127;

    localparam logic [MULT_W-1:0]  MULT_RESET  = 31'd1073741824;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_ZP     = 3'd0,
        REG_SECOND_ZP    = 3'd1,
        REG_RESULT_ZP    = 3'd2,
        REG_FIRST_MULT   = 3'd3,
        REG_FIRST_SHIFT  = 3'd4,
        REG_SECOND_MULT  = 3'd5,
        REG_SECOND_SHIFT = 3'd6
    } cfg_reg_t;

    // load enables of the three term stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

endpackage

[sv/int8_requantized_add.sv]
// int8_requantized_add: elementwise int8 add with per-operand requantisation.
// Input channel (in_valid/in_ready): first_value, second_value, last_in.
// Output channel (out_valid/out_ready): sum_value, last_out.
// Each operand has its zero point removed, is multiplied by its Q31
// multiplier and rounded half-up by its right shift; both terms plus the
// result zero point are summed and saturated to -128..127.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write only while no word is in flight. Unknown indexes are ignored.
// Pipeline: four register stages (zero point subtract, multiply, round/shift,
// sum/saturate); an accepted word passes through them in that order to out_valid.
// Throughput: one word per cycle while out_ready stays high.
// Reset: pipeline empty, registers at zero points 0, multipliers 2^30,
// shifts 30.
// Receiver stall: the output word holds; earlier stages keep filling into
// empty slots, and in_ready drops only once all four stages are full.
module int8_requantized_add (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [iqa_pkg::VAL_W-1:0]       first_value,
    input  logic signed [iqa_pkg::VAL_W-1:0]       second_value,
    input  logic                                   last_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [iqa_pkg::VAL_W-1:0]       sum_value,
    output logic                                   last_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [iqa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [iqa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic signed [iqa_pkg::VAL_W-1:0]   first_zp_reg, second_zp_reg, result_zp_reg;
    logic        [iqa_pkg::MULT_W-1:0]  first_mult_reg, second_mult_reg;
    logic        [iqa_pkg::SHIFT_W-1:0] first_shift_reg, second_shift_reg;

    // pipeline control: valid and last travel with each stage
    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    logic                      l1_reg, l2_reg, l3_reg, l4_reg;
    logic                      en4;
    iqa_pkg::stage_en_t        en;
    logic                      accept;

    logic signed [iqa_pkg::TERM_W-1:0] first_term, second_term;
    logic signed [iqa_pkg::ACC_W-1:0]  acc;
    logic signed [iqa_pkg::VAL_W-1:0]  sum_reg, sum_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_zp_reg     <= '0;
            second_zp_reg    <= '0;
            result_zp_reg    <= '0;
            first_mult_reg   <= iqa_pkg::MULT_RESET;
            first_shift_reg  <= iqa_pkg::SHIFT_RESET;
            second_mult_reg  <= iqa_pkg::MULT_RESET;
            second_shift_reg <= iqa_pkg::SHIFT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (iqa_pkg::cfg_reg_t'(cfg_index))
                iqa_pkg::REG_FIRST_ZP:     first_zp_reg     <= cfg_data[iqa_pkg::VAL_W-1:0];
                iqa_pkg::REG_SECOND_ZP:    second_zp_reg    <= cfg_data[iqa_pkg::VAL_W-1:0];
                iqa_pkg::REG_RESULT_ZP:    result_zp_reg    <= cfg_data[iqa_pkg::VAL_W-1:0];
                iqa_pkg::REG_FIRST_MULT:   first_mult_reg   <= cfg_data;
                iqa_pkg::REG_FIRST_SHIFT:  first_shift_reg  <= cfg_data[iqa_pkg::SHIFT_W-1:0];
                iqa_pkg::REG_SECOND_MULT:  second_mult_reg  <= cfg_data;
                iqa_pkg::REG_SECOND_SHIFT: second_shift_reg <= cfg_data[iqa_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or the stage after it moves on
    always_comb
    begin
        en4   = !v4_reg || out_ready;
        en.s3 = !v3_reg || en4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign in_ready = en.s1;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= in_valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    iqa_term u_first (
        .clk        (clk),
        .en         (en),
        .value      (first_value),
        .zero_point (first_zp_reg),
        .multiplier (first_mult_reg),
        .shift      (first_shift_reg),
        .term       (first_term)
    );

    iqa_term u_second (
        .clk        (clk),
        .en         (en),
        .value      (second_value),
        .zero_point (second_zp_reg),
        .multiplier (second_mult_reg),
        .shift      (second_shift_reg),
        .term       (second_term)
    );

    // stage 4: sum both terms and the result zero point, then saturate
    always_comb
    begin
        acc = iqa_pkg::ACC_W'(first_term) + iqa_pkg::ACC_W'(second_term)
            + iqa_pkg::ACC_W'(result_zp_reg);
        if (acc < iqa_pkg::SUM_MIN)
        begin
            sum_next = iqa_pkg::SUM_MIN[iqa_pkg::VAL_W-1:0];
        end
        else if (acc > iqa_pkg::SUM_MAX)
        begin
            sum_next = iqa_pkg::SUM_MAX[iqa_pkg::VAL_W-1:0];
        end
        else
        begin
            sum_next = acc[iqa_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            l1_reg <= last_in;
        end
        if (en.s2)
        begin
            l2_reg <= l1_reg;
        end
        if (en.s3)
        begin
            l3_reg <= l2_reg;
        end
        if (en4)
        begin
            l4_reg  <= l3_reg;
            sum_reg <= sum_next;
        end
    end

    assign out_valid = v4_reg;
    assign sum_value = sum_reg;
    assign last_out  = l4_reg;

    // an accepted word always lands in stage 1
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v1_reg)
        else $error("accepted word did not enter stage 1");

    // input only blocks when the whole pipe is occupied
    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(v1_reg && v2_reg && v3_reg && v4_reg) |-> in_ready)
        else $error("input stalled with room in the pipeline");

    // a word leaving stage 3 reaches the output register
    a_stage3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && en4) |=> out_valid)
        else $error("word lost between stage 3 and output");

endmodule

[sv/iqa_term.sv]
// One operand: zero point removal, Q31 multiply, round-half-up shift.
// Three register stages; loads follow the enables from the top level.
module iqa_term (
    input  logic                                  clk,
    input  iqa_pkg::stage_en_t                    en,
    input  logic signed [iqa_pkg::VAL_W-1:0]      value,
    input  logic signed [iqa_pkg::VAL_W-1:0]      zero_point,
    input  logic        [iqa_pkg::MULT_W-1:0]     multiplier,
    input  logic        [iqa_pkg::SHIFT_W-1:0]    shift,
    output logic signed [iqa_pkg::TERM_W-1:0]     term
);

    logic signed [iqa_pkg::DIFF_W-1:0]   diff_reg, diff_next;
    logic signed [iqa_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [iqa_pkg::PROD_W:0]     prod_full;
    logic signed [iqa_pkg::TERM_W-1:0]   term_reg, term_next;
    logic signed [iqa_pkg::ACC_W-1:0]    prod_ext, rnd, rsum, shifted;
    logic        [iqa_pkg::SHIFT_W-1:0]  shift_m1;

    // stage 1: subtract zero point
    assign diff_next = iqa_pkg::DIFF_W'(value) - iqa_pkg::DIFF_W'(zero_point);

    // stage 2: signed 9 x unsigned 31 multiply
    assign prod_full = diff_reg * $signed({1'b0, multiplier});
    assign prod_next = prod_full[iqa_pkg::PROD_W-1:0];

    // stage 3: add half an output LSB, arithmetic shift
    always_comb
    begin
        shift_m1 = shift - iqa_pkg::SHIFT_W'(1);
        prod_ext = iqa_pkg::ACC_W'(prod_reg);
        rnd      = iqa_pkg::ACC_W'(1) << shift_m1;
        rsum     = prod_ext + rnd;
        shifted  = rsum >>> shift;
        if (shift == '0)
        begin
            term_next = iqa_pkg::TERM_W'(prod_reg);
        end
        else if (shift > iqa_pkg::SHIFT_ZERO_ABOVE)
        begin
            term_next = '0;
        end
        else
        begin
            term_next = shifted[iqa_pkg::TERM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            diff_reg <= diff_next;
        end
        if (en.s2)
        begin
            prod_reg <= prod_next;
        end
        if (en.s3)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule
